>>> rtl/fac_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fac_pkg: shared types and constants for the frustum box culler
// Word layouts for both channels, the plane record and the stage enables.
// ----------------------------------------------------------------------------
package fac_pkg;

  localparam int FIELD_W = 32;  // every coefficient and coordinate field
  localparam int IDX_W   = 3;   // plane_index and reject_plane
  localparam int FRAC_W  = 16;  // fraction bits of the Q16.16 inputs

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TEST = 1'b1;

  typedef struct packed {
    logic                      opcode;
    logic [IDX_W-1:0]          plane_index;
    logic signed [FIELD_W-1:0] plane_a;
    logic signed [FIELD_W-1:0] plane_b;
    logic signed [FIELD_W-1:0] plane_c;
    logic signed [FIELD_W-1:0] plane_d;
    logic signed [FIELD_W-1:0] min_x;
    logic signed [FIELD_W-1:0] min_y;
    logic signed [FIELD_W-1:0] min_z;
    logic signed [FIELD_W-1:0] max_x;
    logic signed [FIELD_W-1:0] max_y;
    logic signed [FIELD_W-1:0] max_z;
  } in_word_t;

  typedef struct packed {
    logic             inside_res;
    logic [IDX_W-1:0] reject_plane;
  } out_word_t;

  typedef struct packed {
    logic [FIELD_W-1:0] a;
    logic [FIELD_W-1:0] b;
    logic [FIELD_W-1:0] c;
    logic [FIELD_W-1:0] d;
  } plane_t;

  // load enables of the lane stages, one per register rank
  typedef struct packed {
    logic en_s2;
    logic en_s3;
    logic en_s4;
    logic en_s5;
  } pipe_ctl_t;

endpackage

>>> rtl/fac_plane_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fac_plane_store: plane coefficient registers
// One row of a, b, c, d per plane; each row is read by its own lane.
// ----------------------------------------------------------------------------
module fac_plane_store #(
  parameter int NUM_PLANES = 6
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      wr_en,
  input  logic [fac_pkg::IDX_W-1:0] wr_idx,
  input  fac_pkg::plane_t           wr_plane,
  output fac_pkg::plane_t           planes [NUM_PLANES]
);
  import fac_pkg::*;

  plane_t planes_r [NUM_PLANES];

  // slots past the plane count never match, so such loads drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < NUM_PLANES; p++) begin
        planes_r[p] <= '0;
      end
    end else begin
      for (int p = 0; p < NUM_PLANES; p++) begin
        if (wr_en && (int'(wr_idx) == p)) begin
          planes_r[p] <= wr_plane;
        end
      end
    end
  end

  assign planes = planes_r;

endmodule

>>> rtl/fac_plane_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fac_plane_lane: p-vertex / n-vertex test of one plane
// Corner select and split multiplies, product merge, two half sums,
// final sum and sign check; four register ranks.
// ----------------------------------------------------------------------------
module fac_plane_lane #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk,
  input  fac_pkg::pipe_ctl_t            ctl,
  input  fac_pkg::plane_t               plane,
  input  logic signed [COORD_WIDTH-1:0] box_lo [3],
  input  logic signed [COORD_WIDTH-1:0] box_hi [3],
  output logic                          accept
);
  import fac_pkg::*;

  localparam int CW  = COORD_WIDTH;
  localparam int LW  = CW / 2;       // unsigned low slice of a coordinate
  localparam int HW  = CW - LW;      // signed high slice
  localparam int PLW = CW + LW + 1;  // coef * low slice
  localparam int PHW = CW + HW;      // coef * high slice
  localparam int SW  = 2 * CW + 2;   // exact sum of three products and offset

  logic signed [CW-1:0]  coef [3];
  logic signed [CW-1:0]  d_s;
  logic signed [CW-1:0]  sel;
  logic signed [PLW-1:0] pl_nxt [2][3];
  logic signed [PHW-1:0] ph_nxt [2][3];
  logic signed [PLW-1:0] pl2_r  [2][3];
  logic signed [PHW-1:0] ph2_r  [2][3];
  logic signed [CW-1:0]  d2_r;
  logic signed [CW-1:0]  d3_r;
  logic signed [SW-1:0]  prod_nxt [2][3];
  logic signed [SW-1:0]  prod3_r  [2][3];
  logic signed [SW-1:0]  ph_ext;
  logic signed [SW-1:0]  pl_ext;
  logic signed [SW-1:0]  d_al;
  logic signed [SW-1:0]  ha_nxt [2];
  logic signed [SW-1:0]  hb_nxt [2];
  logic signed [SW-1:0]  ha4_r  [2];
  logic signed [SW-1:0]  hb4_r  [2];
  logic signed [SW-1:0]  total;
  logic                  acc_nxt;
  logic                  acc5_r;

  // stage 1 -> 2: corner pick by normal sign (zero counts as positive),
  // then coef * coordinate as two narrow partial products
  always_comb begin
    coef[0] = CW'(plane.a);
    coef[1] = CW'(plane.b);
    coef[2] = CW'(plane.c);
    d_s     = CW'(plane.d);
    sel     = '0;
    for (int c = 0; c < 2; c++) begin
      for (int k = 0; k < 3; k++) begin
        // corner 0 is the positive vertex, corner 1 the negative one
        sel          = (coef[k][CW-1] ^ 1'(c)) ? box_lo[k] : box_hi[k];
        pl_nxt[c][k] = coef[k] * $signed({1'b0, sel[LW-1:0]});
        ph_nxt[c][k] = coef[k] * $signed(sel[CW-1:LW]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en_s2) begin
      pl2_r <= pl_nxt;
      ph2_r <= ph_nxt;
      d2_r  <= d_s;
    end
  end

  // stage 2 -> 3: merge partials
  always_comb begin
    ph_ext = '0;
    pl_ext = '0;
    for (int c = 0; c < 2; c++) begin
      for (int k = 0; k < 3; k++) begin
        ph_ext         = SW'(ph2_r[c][k]);
        pl_ext         = SW'(pl2_r[c][k]);
        prod_nxt[c][k] = (ph_ext <<< LW) + pl_ext;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en_s3) begin
      prod3_r <= prod_nxt;
      d3_r    <= d2_r;
    end
  end

  // stage 3 -> 4: offset to Q32.32, two half sums per corner
  always_comb begin
    d_al = SW'(d3_r) <<< FRAC_W;
    for (int c = 0; c < 2; c++) begin
      ha_nxt[c] = prod3_r[c][0] + prod3_r[c][1];
      hb_nxt[c] = prod3_r[c][2] + d_al;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en_s4) begin
      ha4_r <= ha_nxt;
      hb4_r <= hb_nxt;
    end
  end

  // stage 4 -> 5: plane keeps the box if either corner is on or above it
  always_comb begin
    acc_nxt = 1'b0;
    total   = '0;
    for (int c = 0; c < 2; c++) begin
      total   = ha4_r[c] + hb4_r[c];
      acc_nxt = acc_nxt | ~total[SW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en_s5) begin
      acc5_r <= acc_nxt;
    end
  end

  assign accept = acc5_r;

endmodule

>>> rtl/frustum_aabb_cull.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frustum_aabb_cull: box versus frustum culling, p-vertex test
// Holds NUM_PLANES planes and tests axis-aligned boxes against all of them.
// ----------------------------------------------------------------------------
// Usage: a word with opcode OP_LOAD writes plane plane_index (slots at or past
// NUM_PLANES are dropped) and returns nothing; a word with opcode OP_TEST
// returns one word: inside_res, and reject_plane = lowest rejecting plane or
// NUM_PLANES if none. A test sees every load accepted before it. One word is
// taken per clock while in_ready is high; a test passes through the input
// rank, split multiplies, product merge, half sums, final sum and sign and
// output register in turn. All planes run in parallel lanes. Each rank only
// holds when the rank after it is full and stalled, so bubbles close up
// behind a waiting result. Planes reset to zero, which accepts every box.
// ----------------------------------------------------------------------------
module frustum_aabb_cull #(
  parameter int NUM_PLANES  = 6,
  parameter int COORD_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  fac_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output fac_pkg::out_word_t out_data
);
  import fac_pkg::*;

  localparam int CW    = COORD_WIDTH;
  localparam int REJ_W = $clog2(NUM_PLANES + 1);
  localparam logic [IDX_W-1:0] REJ_NONE = IDX_W'(NUM_PLANES);

  // handshake / stage control
  logic      en_s1, en_out;
  pipe_ctl_t ctl;
  logic      v1_r, v2_r, v3_r, v4_r, v5_r;
  logic      out_valid_r;
  logic      in_acc;
  logic      load_wr;

  // S1 box rank
  logic signed [CW-1:0] lo_nxt [3];
  logic signed [CW-1:0] hi_nxt [3];
  logic signed [CW-1:0] box_lo_r [3];
  logic signed [CW-1:0] box_hi_r [3];

  plane_t               planes [NUM_PLANES];
  plane_t               wr_plane;
  logic [NUM_PLANES-1:0] acc_mask;

  logic [REJ_W-1:0] rej;
  out_word_t        out_data_nxt;
  out_word_t        out_data_r;

  // per-rank enables: a rank loads when empty or when the next rank moves
  always_comb begin
    en_out    = !out_valid_r || out_ready;
    ctl.en_s5 = !v5_r || en_out;
    ctl.en_s4 = !v4_r || ctl.en_s5;
    ctl.en_s3 = !v3_r || ctl.en_s4;
    ctl.en_s2 = !v2_r || ctl.en_s3;
    en_s1     = !v1_r || ctl.en_s2;
  end

  assign in_ready = en_s1;
  assign in_acc   = in_valid && in_ready;
  // loads write straight into the store at their edge; tests still in S1
  // have already read it, tests behind see the new plane
  assign load_wr  = in_acc && (in_data.opcode == OP_LOAD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en_s1) begin
        v1_r <= in_valid && (in_data.opcode == OP_TEST);
      end
      if (ctl.en_s2) begin
        v2_r <= v1_r;
      end
      if (ctl.en_s3) begin
        v3_r <= v2_r;
      end
      if (ctl.en_s4) begin
        v4_r <= v3_r;
      end
      if (ctl.en_s5) begin
        v5_r <= v4_r;
      end
      if (en_out) begin
        out_valid_r <= v5_r;
      end
    end
  end

  // coordinates are taken from the low COORD_WIDTH bits of each field
  always_comb begin
    lo_nxt[0] = CW'(unsigned'(in_data.min_x));
    lo_nxt[1] = CW'(unsigned'(in_data.min_y));
    lo_nxt[2] = CW'(unsigned'(in_data.min_z));
    hi_nxt[0] = CW'(unsigned'(in_data.max_x));
    hi_nxt[1] = CW'(unsigned'(in_data.max_y));
    hi_nxt[2] = CW'(unsigned'(in_data.max_z));
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      box_lo_r <= lo_nxt;
      box_hi_r <= hi_nxt;
    end
  end

  always_comb begin
    wr_plane.a = in_data.plane_a;
    wr_plane.b = in_data.plane_b;
    wr_plane.c = in_data.plane_c;
    wr_plane.d = in_data.plane_d;
  end

  fac_plane_store #(
    .NUM_PLANES (NUM_PLANES)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (load_wr),
    .wr_idx   (in_data.plane_index),
    .wr_plane (wr_plane),
    .planes   (planes)
  );

  for (genvar p = 0; p < NUM_PLANES; p++) begin : g_lane
    fac_plane_lane #(
      .COORD_WIDTH (COORD_WIDTH)
    ) u_lane (
      .clk    (clk),
      .ctl    (ctl),
      .plane  (planes[p]),
      .box_lo (box_lo_r),
      .box_hi (box_hi_r),
      .accept (acc_mask[p])
    );
  end

  // first rejecting plane; walk down so the lowest index wins
  always_comb begin
    rej = REJ_W'(NUM_PLANES);
    for (int p = NUM_PLANES - 1; p >= 0; p--) begin
      if (!acc_mask[p]) begin
        rej = REJ_W'(p);
      end
    end
    out_data_nxt.inside_res   = &acc_mask;
    out_data_nxt.reject_plane = IDX_W'(rej);
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // an inside result always carries the "none" plane code
  a_inside_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.inside_res |-> out_data.reject_plane == REJ_NONE)
    else $error("inside result with a rejecting plane");

  // a plane load never launches a result
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.opcode == OP_LOAD) |=> !v1_r)
    else $error("load word entered the test pipeline");

  // a new result only comes from a full last rank
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(v5_r))
    else $error("result appeared without a word in the last rank");

  // a load to slot 0 lands in the store on the next cycle
  a_store_wr: assert property (@(posedge clk) disable iff (!rst_n)
    load_wr && (in_data.plane_index == '0)
      |=> planes[0].a == $past(in_data.plane_a) &&
          planes[0].d == $past(in_data.plane_d))
    else $error("plane store write lost");
`endif

endmodule
